>>> rtl/opf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opf_pkg: shared types and constants of the Ogg page framer.
// Holds the parse and controller state types, the command and status
// structs, the page constants and the CRC and frame size functions.
// ----------------------------------------------------------------------------
package opf_pkg;

    localparam int MAX_PACKET_DEF = 4096;
    localparam int FCNT_W         = 16;
    localparam int SEG_W          = 8;
    localparam int LEN_W          = 17;
    localparam int HDR_LEN        = 27;

    localparam logic [31:0] CAPTURE  = 32'h4F676753;
    localparam logic [15:0] SERIAL   = 16'h7667;
    localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
    localparam logic [31:0] SEQ_INIT = 32'd2;
    localparam logic [7:0]  REM_LAST = 8'd254;

    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_SIZE = 2'd1;
    localparam logic [1:0] ERR_DROP = 2'd2;

    typedef enum logic [1:0] {
        PH_SIZE,
        PH_SKIP,
        PH_DATA,
        PH_DROP
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CRC_RD,
        ST_CRC_CALC,
        ST_PULL
    } ctrl_state_t;

    typedef struct packed {
        logic feed;
        logic crc_step;
        logic emit;
    } opf_cmd_t;

    typedef struct packed {
        logic finish;
        logic crc_last;
        logic out_free;
    } opf_stat_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'd0};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [11:0] frame_samples(input logic [7:0] toc);
        logic [1:0] c;
        logic [11:0] r;
        c = toc[4:3];
        if (toc[7]) begin
            r = 12'd120 << c;
        end else if (toc[6:5] == 2'b11) begin
            r = toc[3] ? 12'd960 : 12'd480;
        end else if (c == 2'd3) begin
            r = 12'd2880;
        end else begin
            r = 12'd480 << c;
        end
        return r;
    endfunction

endpackage

>>> rtl/opf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opf_ctrl: sequencer of the Ogg page framer.
// Accepts words, runs the CRC pass over a finished page and waits for the
// result register to free up on a pull.
// ----------------------------------------------------------------------------
module opf_ctrl import opf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      cmd,
    input  opf_stat_t stat,
    output logic      in_stall,
    output opf_cmd_t  ctl
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (cmd == CMD_FEED)
                    begin
                        ctl.feed = 1'b1;
                        if (stat.finish)
                        begin
                            state_next = ST_CRC_RD;
                        end
                    end
                    else
                    begin
                        state_next = ST_PULL;
                    end
                end
            end
            ST_CRC_RD:
            begin
                state_next = ST_CRC_CALC;
            end
            ST_CRC_CALC:
            begin
                ctl.crc_step = 1'b1;
                state_next   = stat.crc_last ? ST_IDLE : ST_CRC_RD;
            end
            ST_PULL:
            begin
                if (stat.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/opf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opf_datapath: packet buffer, page builder and CRC register.
// Parses the size-prefixed stream, stores the packet, forms each page byte
// and holds the result register.
// ----------------------------------------------------------------------------
module opf_datapath import opf_pkg::*;
#(
    parameter int MAX_PACKET = MAX_PACKET_DEF,
    localparam int AW = $clog2(MAX_PACKET)
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] stream_byte,
    input  logic       res_stall,
    input  opf_cmd_t   ctl,
    output opf_stat_t  stat,
    output logic       res_valid,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       page_end,
    output logic [1:0] error_code
);

    logic [7:0] mem [MAX_PACKET];
    logic [7:0] mem_q;

    phase_t              phase_reg, phase_next;
    logic [FCNT_W-1:0]   fcnt_reg, fcnt_next;
    logic [31:0]         psize_reg, psize_next;
    logic [SEG_W-1:0]    quot_reg, quot_next;
    logic [7:0]          rem_reg, rem_next;
    logic [7:0]          toc_reg, toc_next;
    logic [31:0]         seq_reg, seq_next;
    logic [63:0]         total_reg, total_next;
    logic [63:0]         gran_reg, gran_next;
    logic [31:0]         crc_reg, crc_next;
    logic [FCNT_W-1:0]   idx_reg, idx_next;
    logic                ready_reg, ready_next;
    logic [1:0]          err_reg, err_next;
    logic                resv_reg, resv_next;
    logic                ov_reg, ov_next;
    logic [7:0]          ob_reg, ob_next;
    logic                pe_reg, pe_next;
    logic [1:0]          oe_reg, oe_next;

    logic                mem_we;
    logic [SEG_W-1:0]    seg;
    logic [FCNT_W-1:0]   lace_end;
    logic [AW-1:0]       rd_addr;
    logic [LEN_W-1:0]    page_len;
    logic                last;
    logic [7:0]          pbyte;
    logic [7:0]          toc_eff;
    logic [11:0]         spf;
    logic [32:0]         fcnt_inc;

    assign seg      = quot_reg + SEG_W'(1);
    assign lace_end = FCNT_W'(HDR_LEN) + FCNT_W'(seg);
    assign rd_addr  = AW'(idx_reg - lace_end);
    assign page_len = LEN_W'(HDR_LEN) + LEN_W'(seg) + psize_reg[LEN_W-1:0];
    assign last     = (LEN_W'(idx_reg) + LEN_W'(1)) >= page_len;
    assign fcnt_inc = 33'(fcnt_reg) + 33'd1;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[fcnt_reg[AW-1:0]] <= stream_byte;
        end
        mem_q <= mem[rd_addr];
    end

    always_comb
    begin
        pbyte = 8'd0;
        if (idx_reg < FCNT_W'(HDR_LEN))
        begin
            case (idx_reg[4:0])
                5'd0:  pbyte = CAPTURE[31:24];
                5'd1:  pbyte = CAPTURE[23:16];
                5'd2:  pbyte = CAPTURE[15:8];
                5'd3:  pbyte = CAPTURE[7:0];
                5'd5:  pbyte = (seq_reg == 32'd0) ? 8'd2 : 8'd0;
                5'd6:  pbyte = gran_reg[7:0];
                5'd7:  pbyte = gran_reg[15:8];
                5'd8:  pbyte = gran_reg[23:16];
                5'd9:  pbyte = gran_reg[31:24];
                5'd10: pbyte = gran_reg[39:32];
                5'd11: pbyte = gran_reg[47:40];
                5'd12: pbyte = gran_reg[55:48];
                5'd13: pbyte = gran_reg[63:56];
                5'd14: pbyte = SERIAL[7:0];
                5'd15: pbyte = SERIAL[15:8];
                5'd18: pbyte = seq_reg[7:0];
                5'd19: pbyte = seq_reg[15:8];
                5'd20: pbyte = seq_reg[23:16];
                5'd21: pbyte = seq_reg[31:24];
                5'd22: pbyte = ctl.crc_step ? 8'd0 : crc_reg[7:0];
                5'd23: pbyte = ctl.crc_step ? 8'd0 : crc_reg[15:8];
                5'd24: pbyte = ctl.crc_step ? 8'd0 : crc_reg[23:16];
                5'd25: pbyte = ctl.crc_step ? 8'd0 : crc_reg[31:24];
                5'd26: pbyte = seg;
                default: pbyte = 8'd0;
            endcase
        end
        else if (idx_reg < lace_end)
        begin
            pbyte = ((idx_reg + FCNT_W'(1)) < lace_end) ? 8'hFF : rem_reg;
        end
        else
        begin
            pbyte = mem_q;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        fcnt_next  = fcnt_reg;
        psize_next = psize_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        toc_next   = toc_reg;
        seq_next   = seq_reg;
        total_next = total_reg;
        gran_next  = gran_reg;
        crc_next   = crc_reg;
        idx_next   = idx_reg;
        ready_next = ready_reg;
        err_next   = err_reg;
        resv_next  = resv_reg;
        ov_next    = ov_reg;
        ob_next    = ob_reg;
        pe_next    = pe_reg;
        oe_next    = oe_reg;
        mem_we     = 1'b0;
        stat       = '0;
        spf        = 12'd0;
        toc_eff    = toc_reg;

        if (ctl.feed)
        begin
            if (ready_reg)
            begin
                if (err_reg == ERR_NONE)
                begin
                    err_next = ERR_DROP;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_SIZE:
                    begin
                        psize_next = (fcnt_reg == '0) ? {24'd0, stream_byte}
                                                      : {psize_reg[23:0], stream_byte};
                        fcnt_next  = fcnt_reg + FCNT_W'(1);
                        if (fcnt_reg == FCNT_W'(3))
                        begin
                            fcnt_next  = '0;
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_SKIP:
                    begin
                        fcnt_next = fcnt_reg + FCNT_W'(1);
                        if (fcnt_reg == FCNT_W'(3))
                        begin
                            fcnt_next = '0;
                            quot_next = '0;
                            rem_next  = 8'd0;
                            if (psize_reg > 32'(MAX_PACKET))
                            begin
                                if (err_reg == ERR_NONE)
                                begin
                                    err_next = ERR_SIZE;
                                end
                                phase_next = PH_DROP;
                            end
                            else if (psize_reg == 32'd0)
                            begin
                                stat.finish = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        mem_we    = 1'b1;
                        fcnt_next = fcnt_reg + FCNT_W'(1);
                        if (fcnt_reg == '0)
                        begin
                            toc_next = stream_byte;
                            toc_eff  = stream_byte;
                        end
                        if (rem_reg == REM_LAST)
                        begin
                            rem_next  = 8'd0;
                            quot_next = quot_reg + SEG_W'(1);
                        end
                        else
                        begin
                            rem_next = rem_reg + 8'd1;
                        end
                        if (fcnt_inc >= {1'b0, psize_reg})
                        begin
                            stat.finish = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (psize_reg > 32'd1)
                        begin
                            psize_next = psize_reg - 32'd1;
                        end
                        else
                        begin
                            psize_next = 32'd0;
                            phase_next = PH_SIZE;
                            fcnt_next  = '0;
                        end
                    end
                endcase
            end
        end

        if (stat.finish)
        begin
            if (psize_reg != 32'd0)
            begin
                spf = frame_samples(toc_eff);
            end
            total_next = total_reg + 64'(spf);
            gran_next  = total_next;
            crc_next   = 32'd0;
            idx_next   = '0;
            phase_next = PH_SIZE;
            fcnt_next  = '0;
        end

        if (ctl.crc_step)
        begin
            crc_next = crc_byte(crc_reg, pbyte);
            if (last)
            begin
                idx_next   = '0;
                ready_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + FCNT_W'(1);
            end
        end
        stat.crc_last = last;

        stat.out_free = !resv_reg || !res_stall;
        if (resv_reg && !res_stall)
        begin
            resv_next = 1'b0;
        end
        if (ctl.emit)
        begin
            resv_next = 1'b1;
            ov_next   = ready_reg;
            ob_next   = ready_reg ? pbyte : 8'd0;
            pe_next   = ready_reg && last;
            oe_next   = err_reg;
            if (ready_reg)
            begin
                if (last)
                begin
                    ready_next = 1'b0;
                    idx_next   = '0;
                    seq_next   = seq_reg + 32'd1;
                end
                else
                begin
                    idx_next = idx_reg + FCNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIZE;
            fcnt_reg  <= '0;
            psize_reg <= 32'd0;
            quot_reg  <= '0;
            rem_reg   <= 8'd0;
            seq_reg   <= SEQ_INIT;
            total_reg <= 64'd0;
            gran_reg  <= 64'd0;
            crc_reg   <= 32'd0;
            idx_reg   <= '0;
            ready_reg <= 1'b0;
            err_reg   <= ERR_NONE;
            resv_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            fcnt_reg  <= fcnt_next;
            psize_reg <= psize_next;
            quot_reg  <= quot_next;
            rem_reg   <= rem_next;
            seq_reg   <= seq_next;
            total_reg <= total_next;
            gran_reg  <= gran_next;
            crc_reg   <= crc_next;
            idx_reg   <= idx_next;
            ready_reg <= ready_next;
            err_reg   <= err_next;
            resv_reg  <= resv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        toc_reg <= toc_next;
        ov_reg  <= ov_next;
        ob_reg  <= ob_next;
        pe_reg  <= pe_next;
        oe_reg  <= oe_next;
    end

    assign res_valid  = resv_reg;
    assign out_valid  = ov_reg;
    assign out_byte   = ob_reg;
    assign page_end   = pe_reg;
    assign error_code = oe_reg;

endmodule

>>> rtl/opus_packet_ogg_page_framer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opus_packet_ogg_page_framer_core: Ogg page framer for Opus packets.
// Buffers each fitting size-prefixed packet and reads it out as one Ogg page.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, cmd, stream_byte) carries one word
// per handshake. A feed word delivers one stream byte; a pull word asks for
// the next page byte and yields exactly one word on the result channel
// (res_valid, res_stall, out_valid, out_byte, page_end, error_code).
// The feed that completes a packet starts a CRC pass over the whole page,
// visiting the CRC read and CRC calc states for each page byte because the
// packet buffer read is registered; the block stalls its input for the pass.
// A pull moves the controller to its pull state, which loads the result into
// the output register once that register is free; the result then holds
// while res_stall is high, and the input stays stalled until that register
// can take the result.
// Reset clears the parser, the page sequence (back to two), the sample
// total and the error code; the packet buffer is not cleared.
// ----------------------------------------------------------------------------
module opus_packet_ogg_page_framer_core import opf_pkg::*;
#(
    parameter int MAX_PACKET = MAX_PACKET_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       cmd,
    input  logic [7:0] stream_byte,
    output logic       res_valid,
    input  logic       res_stall,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       page_end,
    output logic [1:0] error_code
);

    opf_cmd_t  ctl;
    opf_stat_t stat;

    opf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .stat     (stat),
        .in_stall (in_stall),
        .ctl      (ctl)
    );

    opf_datapath #(.MAX_PACKET(MAX_PACKET)) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .stream_byte (stream_byte),
        .res_stall   (res_stall),
        .ctl         (ctl),
        .stat        (stat),
        .res_valid   (res_valid),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .page_end    (page_end),
        .error_code  (error_code)
    );

`ifndef SYNTH
    a_end_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && page_end) |-> out_valid)
        else $error("page_end set on a result without a page byte");

    a_err_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (error_code == ERR_NONE || error_code == ERR_SIZE ||
                       error_code == ERR_DROP))
        else $error("illegal error code");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && error_code != ERR_NONE) |=> (error_code == $past(error_code)))
        else $error("sticky error code changed");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.feed, ctl.crc_step, ctl.emit}))
        else $error("controller issued more than one command");
`endif

endmodule
